// ----- src/dcti_pkg.sv -----
// Package for the dual countdown timer block: counter width, command codes,
// control and state structs, and the input and result item types.
// No dependencies.
package dcti_pkg;

  localparam int TIMER_WIDTH = 32;
  localparam int ITEM_VALUE_WIDTH = 32;
  localparam int NUM_TIMERS = 2;

  typedef logic [TIMER_WIDTH-1:0] cnt_t;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_WRCTL = 3'd3,
    CMD_START = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_e;

  // per-timer control bits
  typedef struct packed {
    logic srq;
    logic wake;
    logic intr;
    logic run;
  } ctrl_t;

  typedef struct packed {
    cnt_t  cnt;
    ctrl_t ctl;
    logic  started;
  } timer_state_t;

  typedef struct packed {
    logic [2:0]                  command;
    logic                        chip;
    logic [ITEM_VALUE_WIDTH-1:0] value;
    logic                        new_run;
    logic                        new_intr_enable;
    logic                        new_wake_enable;
    logic                        cpu_sleeping;
    logic                        int_enable;
    logic                        master_enabled;
  } in_item_t;

  typedef struct packed {
    logic [ITEM_VALUE_WIDTH-1:0] timer_value;
    logic                        run_bit;
    logic                        intr_bit;
    logic                        wake_bit;
    logic                        service_request;
    logic                        interrupt_raised;
    logic                        wake_raised;
  } res_item_t;

endpackage

// ----- src/dcti_if.sv -----
// Channel interfaces for the dual countdown timer block: command item input
// and result item output, each with valid/ready and payload.
// No dependencies.
interface dcti_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic        chip;
  logic [31:0] value;
  logic        new_run;
  logic        new_intr_enable;
  logic        new_wake_enable;
  logic        cpu_sleeping;
  logic        int_enable;
  logic        master_enabled;

  modport source (
    output valid, command, chip, value, new_run, new_intr_enable,
           new_wake_enable, cpu_sleeping, int_enable, master_enabled,
    input  ready
  );
  modport sink (
    input  valid, command, chip, value, new_run, new_intr_enable,
           new_wake_enable, cpu_sleeping, int_enable, master_enabled,
    output ready
  );
endinterface

interface dcti_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] timer_value;
  logic        run_bit;
  logic        intr_bit;
  logic        wake_bit;
  logic        service_request;
  logic        interrupt_raised;
  logic        wake_raised;

  modport source (
    output valid, timer_value, run_bit, intr_bit, wake_bit, service_request,
           interrupt_raised, wake_raised,
    input  ready
  );
  modport sink (
    input  valid, timer_value, run_bit, intr_bit, wake_bit, service_request,
           interrupt_raised, wake_raised,
    output ready
  );
endinterface

// ----- src/dcti_core.sv -----
// Next-state and result logic of both timers for one command item.
// Purely combinational; depends on dcti_pkg.
module dcti_core (
  input  dcti_pkg::in_item_t                          item,
  input  dcti_pkg::timer_state_t [dcti_pkg::NUM_TIMERS-1:0] st,
  output dcti_pkg::timer_state_t [dcti_pkg::NUM_TIMERS-1:0] st_nxt,
  output dcti_pkg::res_item_t                         res
);
  import dcti_pkg::*;

  typedef struct packed {
    ctrl_t ctl;
    logic  irq;
    logic  wake;
  } svc_t;

  // hold the count at all ones while an interrupt is pending
  function automatic cnt_t hold_cnt(cnt_t c, ctrl_t k, logic slp, logic gie);
    cnt_t r;
    r = c;
    if (gie && c[TIMER_WIDTH-1] && (!slp || k.wake) && k.intr) r = '1;
    return r;
  endfunction

  // service request update and interrupt / wake pulses
  function automatic svc_t svc_check(cnt_t c, ctrl_t k, logic slp);
    svc_t s;
    s.ctl  = k;
    s.irq  = 1'b0;
    s.wake = 1'b0;
    if (!c[TIMER_WIDTH-1]) begin
      s.ctl.srq = 1'b0;
    end else begin
      if (k.wake || k.intr) s.ctl.srq = 1'b1;
      if ((!slp || k.wake) && k.intr) s.irq = 1'b1;
      if (slp && k.wake) begin
        s.ctl.wake = 1'b0;
        s.wake     = 1'b1;
      end
    end
    return s;
  endfunction

  cmd_e                            cmd;
  cnt_t                            wr_cnt;
  timer_state_t [NUM_TIMERS-1:0]   v;
  svc_t         [NUM_TIMERS-1:0]   sv;
  logic         [NUM_TIMERS-1:0]   do_svc;
  logic         [NUM_TIMERS-1:0]   under;
  logic         [NUM_TIMERS-1:0]   sel;
  logic         [NUM_TIMERS-1:0]   slave_stop;
  logic         [NUM_TIMERS-1:0]   start_ok;
  logic                            any_irq;
  logic                            any_wake;
  timer_state_t                    rep;

  assign cmd    = cmd_e'(item.command);
  assign wr_cnt = item.value[TIMER_WIDTH-1:0];

  // per-timer update; the slave timer's start and stop depend on the master
  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      v[i]          = st[i];
      do_svc[i]     = 1'b0;
      sel[i]        = (item.chip == 1'(i));
      under[i]      = (st[i].cnt == '0);
      slave_stop[i] = (i != 0) && !item.chip;
      start_ok[i]   = item.master_enabled && ((i == 0) || st[0].ctl.run) &&
                      st[i].ctl.run && !st[i].started;
      case (cmd)
        CMD_TICK: begin
          if (st[i].started) begin
            v[i].cnt  = hold_cnt(st[i].cnt - cnt_t'(1), st[i].ctl,
                                 item.cpu_sleeping, item.int_enable);
            do_svc[i] = under[i];
          end
        end
        CMD_READ: begin
          if (sel[i]) begin
            if (st[i].started)
              v[i].cnt = hold_cnt(st[i].cnt, st[i].ctl,
                                  item.cpu_sleeping, item.int_enable);
            do_svc[i] = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (sel[i]) begin
            v[i].cnt  = wr_cnt;
            do_svc[i] = 1'b1;
          end
        end
        CMD_WRCTL: begin
          if (sel[i]) begin
            v[i].ctl.run  = item.new_run;
            v[i].ctl.intr = item.new_intr_enable;
            v[i].ctl.wake = item.new_wake_enable;
          end
        end
        CMD_START: begin
          if (sel[i] && start_ok[i]) begin
            v[i].started = 1'b1;
            do_svc[i]    = 1'b1;
          end
        end
        CMD_STOP: begin
          if (sel[i] || slave_stop[i]) begin
            if (st[i].started)
              v[i].cnt = hold_cnt(st[i].cnt, st[i].ctl,
                                  item.cpu_sleeping, item.int_enable);
            v[i].started = 1'b0;
          end
        end
        default: begin
        end
      endcase
      sv[i]     = svc_check(v[i].cnt, v[i].ctl, item.cpu_sleeping);
      st_nxt[i] = v[i];
      if (do_svc[i]) st_nxt[i].ctl = sv[i].ctl;
    end
  end

  // pulses from either timer
  always_comb begin
    any_irq  = 1'b0;
    any_wake = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      any_irq  = any_irq  | (do_svc[i] & sv[i].irq);
      any_wake = any_wake | (do_svc[i] & sv[i].wake);
    end
  end

  // report the addressed timer
  assign rep                  = st_nxt[item.chip];
  assign res.timer_value      = ITEM_VALUE_WIDTH'(rep.cnt);
  assign res.run_bit          = rep.ctl.run;
  assign res.intr_bit         = rep.ctl.intr;
  assign res.wake_bit         = rep.ctl.wake;
  assign res.service_request  = rep.ctl.srq;
  assign res.interrupt_raised = any_irq;
  assign res.wake_raised      = any_wake;

endmodule

// ----- src/dual_countdown_timer_irq_wake_unit.sv -----
// An accepted item is registered, then processed into the result register once
// the result slot is free or being drained. Throughput: one item per cycle
// unless the output stalls; the input register and the result register part
// the two channels, the input stalls only while both are full and stalled.
// Reset (rst_n low, synchronous): counts zero, control bits clear, timers not
// started, both pipeline registers empty. Depends on dcti_pkg, dcti_if, dcti_core.
module dual_countdown_timer_irq_wake_unit (
  input  logic      clk,
  input  logic      rst_n,
  dcti_in_if.sink   in_ch,
  dcti_out_if.source out_ch
);
  import dcti_pkg::*;

  logic                          s1_valid_r;
  in_item_t                      s1_item_r;
  in_item_t                      s1_item_nxt;
  timer_state_t [NUM_TIMERS-1:0] state_r;
  timer_state_t [NUM_TIMERS-1:0] state_nxt;
  logic                          out_valid_r;
  res_item_t                     out_res_r;
  res_item_t                     out_res_nxt;
  logic                          process;
  logic                          in_take;

  // handshake: process when the result slot is free or being drained
  assign process  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || process;
  assign in_take  = in_ch.valid && in_ch.ready;

  // gather the input item
  always_comb begin
    s1_item_nxt.command         = in_ch.command;
    s1_item_nxt.chip            = in_ch.chip;
    s1_item_nxt.value           = in_ch.value;
    s1_item_nxt.new_run         = in_ch.new_run;
    s1_item_nxt.new_intr_enable = in_ch.new_intr_enable;
    s1_item_nxt.new_wake_enable = in_ch.new_wake_enable;
    s1_item_nxt.cpu_sleeping    = in_ch.cpu_sleeping;
    s1_item_nxt.int_enable      = in_ch.int_enable;
    s1_item_nxt.master_enabled  = in_ch.master_enabled;
  end

  dcti_core u_core (
    .item   (s1_item_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (out_res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_take) s1_item_r <= s1_item_nxt;
  end

  // timer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (process) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (process) out_res_r <= out_res_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.timer_value      = out_res_r.timer_value;
  assign out_ch.run_bit          = out_res_r.run_bit;
  assign out_ch.intr_bit         = out_res_r.intr_bit;
  assign out_ch.wake_bit         = out_res_r.wake_bit;
  assign out_ch.service_request  = out_res_r.service_request;
  assign out_ch.interrupt_raised = out_res_r.interrupt_raised;
  assign out_ch.wake_raised      = out_res_r.wake_raised;

endmodule

// ----- src/dcti_checker.sv -----
// Port-level assertions for the dual countdown timer block, bound to the top
// level. Depends on dual_countdown_timer_irq_wake_unit.
module dcti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_timer_value,
  input logic        out_irq,
  input logic        out_wake
);

  // a stalled result item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_timer_value) &&
                                $stable(out_irq) && $stable(out_wake))
    else $error("result item changed while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input stalls only behind a full, stalled result slot
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // with output ready now and before, input never stalls
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready && $past(out_ready) |-> in_ready)
    else $error("input stalled with free output");

endmodule

bind dual_countdown_timer_irq_wake_unit dcti_checker u_dcti_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_timer_value (out_ch.timer_value),
  .out_irq         (out_ch.interrupt_raised),
  .out_wake        (out_ch.wake_raised)
);

// ----- tb/dual_countdown_timer_irq_wake_unit_tb.sv -----
// Testbench for dual_countdown_timer_irq_wake_unit: random and directed timer
// commands, a built-in timer predictor and an in-order result scoreboard.
// Depends on dcti_pkg, dcti_if and the unit itself.
module dual_countdown_timer_irq_wake_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcti_pkg::*;

  localparam int ITEM_TARGET      = 1250;
  localparam int DRAIN_AT         = 700;
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES    = 8;

  // command codes the package leaves unnamed; the unit must ignore them
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam cnt_t CNT_ONES = '1;

  logic clk = 1'b0;
  logic rst_n;

  dcti_in_if  in_ch();
  dcti_out_if out_ch();

  dual_countdown_timer_irq_wake_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // timer predictor state
  cnt_t  tmr_count   [NUM_TIMERS];
  ctrl_t tmr_ctl     [NUM_TIMERS];
  bit    tmr_started [NUM_TIMERS];
  bit    irq_pulse;
  bit    wake_pulse;

  // stimulus and scoreboard
  in_item_t  pending_items[$];
  res_item_t expected_results[$];
  in_item_t  offered_item;
  res_item_t observed;
  bit        offer_pending = 1'b0;
  int        items_offered = 0;
  int        items_accepted = 0;
  int        results_checked = 0;
  int        mismatch_count = 0;
  int        hold_left = 0;
  bit        long_hold_done = 1'b0;

  // a negative count is pinned at all ones while its interrupt can be taken
  function automatic void hold_at_ones(int t, bit sleeping, bit gie);
    if (gie && tmr_count[t][TIMER_WIDTH-1] && (!sleeping || tmr_ctl[t].wake) &&
        tmr_ctl[t].intr)
      tmr_count[t] = CNT_ONES;
  endfunction

  // service request update, interrupt and wake pulses
  function automatic void update_service(int t, bit sleeping);
    ctrl_t c;
    c = tmr_ctl[t];
    if (!tmr_count[t][TIMER_WIDTH-1]) begin
      c.srq = 1'b0;
    end else begin
      if (c.wake || c.intr) c.srq = 1'b1;
      if ((!sleeping || c.wake) && c.intr) irq_pulse = 1'b1;
      if (sleeping && c.wake) begin
        c.wake = 1'b0;
        wake_pulse = 1'b1;
      end
    end
    tmr_ctl[t] = c;
  endfunction

  function automatic void halt_timer(int t, bit sleeping, bit gie);
    if (tmr_started[t]) hold_at_ones(t, sleeping, gie);
    tmr_started[t] = 1'b0;
  endfunction

  // advance the timer state by one command and return the report it causes
  function automatic res_item_t predict_timer_step(in_item_t it);
    int        t;
    bit        under;
    res_item_t r;
    t = int'(it.chip);
    irq_pulse = 1'b0;
    wake_pulse = 1'b0;
    case (it.command)
      CMD_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (tmr_started[i]) begin
            under = (tmr_count[i] == '0);
            tmr_count[i] = tmr_count[i] - 1'b1;
            hold_at_ones(i, it.cpu_sleeping, it.int_enable);
            if (under) update_service(i, it.cpu_sleeping);
          end
        end
      end
      CMD_READ: begin
        if (tmr_started[t]) hold_at_ones(t, it.cpu_sleeping, it.int_enable);
        update_service(t, it.cpu_sleeping);
      end
      CMD_WRITE: begin
        tmr_count[t] = it.value[TIMER_WIDTH-1:0];
        update_service(t, it.cpu_sleeping);
      end
      CMD_WRCTL: begin
        tmr_ctl[t].run  = it.new_run;
        tmr_ctl[t].intr = it.new_intr_enable;
        tmr_ctl[t].wake = it.new_wake_enable;
      end
      CMD_START: begin
        // slave needs master run; nothing starts twice
        if (it.master_enabled && !(t == 1 && !tmr_ctl[0].run) && tmr_ctl[t].run &&
            !tmr_started[t]) begin
          tmr_started[t] = 1'b1;
          update_service(t, it.cpu_sleeping);
        end
      end
      CMD_STOP: begin
        if (t == 0 && tmr_started[1]) halt_timer(1, it.cpu_sleeping, it.int_enable);
        halt_timer(t, it.cpu_sleeping, it.int_enable);
      end
      default: ;
    endcase
    r.timer_value      = ITEM_VALUE_WIDTH'(tmr_count[t]);
    r.run_bit          = tmr_ctl[t].run;
    r.intr_bit         = tmr_ctl[t].intr;
    r.wake_bit         = tmr_ctl[t].wake;
    r.service_request  = tmr_ctl[t].srq;
    r.interrupt_raised = irq_pulse;
    r.wake_raised      = wake_pulse;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] result %0d: %s got %0h, want %0h", $time, results_checked, field,
             got, want);
  endtask

  task automatic check_result(res_item_t got, res_item_t want);
    if (got.timer_value !== want.timer_value)
      report_mismatch("timer_value", got.timer_value, want.timer_value);
    if (got.run_bit !== want.run_bit)
      report_mismatch("run_bit", 32'(got.run_bit), 32'(want.run_bit));
    if (got.intr_bit !== want.intr_bit)
      report_mismatch("intr_bit", 32'(got.intr_bit), 32'(want.intr_bit));
    if (got.wake_bit !== want.wake_bit)
      report_mismatch("wake_bit", 32'(got.wake_bit), 32'(want.wake_bit));
    if (got.service_request !== want.service_request)
      report_mismatch("service_request", 32'(got.service_request),
                      32'(want.service_request));
    if (got.interrupt_raised !== want.interrupt_raised)
      report_mismatch("interrupt_raised", 32'(got.interrupt_raised),
                      32'(want.interrupt_raised));
    if (got.wake_raised !== want.wake_raised)
      report_mismatch("wake_raised", 32'(got.wake_raised), 32'(want.wake_raised));
  endtask

  // rie = {run, intr enable, wake enable}, env = {sleeping, global irq enable, master}
  function automatic in_item_t make_item(logic [2:0] cmd, bit chip, logic [31:0] value,
                                         bit [2:0] rie, bit [2:0] env);
    in_item_t it;
    it.command         = cmd;
    it.chip            = chip;
    it.value           = value;
    it.new_run         = rie[2];
    it.new_intr_enable = rie[1];
    it.new_wake_enable = rie[0];
    it.cpu_sleeping    = env[2];
    it.int_enable      = env[1];
    it.master_enabled  = env[0];
    return it;
  endfunction

  // counts near underflow and near the sign boundary, plus full random
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'($urandom_range(1, 4));
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'hFFFF_FFFF;
      5:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [2:0] random_env();
    return {1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
            $urandom_range(0, 9) != 0};
  endfunction

  function automatic in_item_t noise_item();
    logic [2:0] cmd;
    if ($urandom_range(0, 39) == 0) cmd = 3'($urandom_range(6, 7));
    else cmd = 3'($urandom_range(0, 5));
    return make_item(cmd, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? pick_value() : $urandom,
                     3'($urandom), 3'($urandom));
  endfunction

  // program a timer, load it, start it, run it down and maybe stop it
  task automatic queue_timer_sequence();
    bit t;
    int steps;
    t = 1'($urandom_range(0, 1));
    if (t)
      pending_items.push_back(make_item(CMD_WRCTL, 1'b0, $urandom,
                                        {1'b1, 2'($urandom)}, random_env()));
    pending_items.push_back(make_item(CMD_WRCTL, t, $urandom,
                                      {$urandom_range(0, 9) != 0, 2'($urandom)},
                                      random_env()));
    pending_items.push_back(make_item(CMD_WRITE, t, pick_value(), 3'($urandom),
                                      random_env()));
    pending_items.push_back(make_item(CMD_START, t, $urandom, 3'($urandom),
                                      random_env()));
    steps = $urandom_range(2, 12);
    repeat (steps) begin
      case ($urandom_range(0, 19))
        14, 15, 16, 17:
          pending_items.push_back(make_item(CMD_READ, 1'($urandom_range(0, 1)), $urandom,
                                            3'($urandom), random_env()));
        18:
          pending_items.push_back(make_item(CMD_WRITE, t, 32'($urandom_range(0, 3)),
                                            3'($urandom), random_env()));
        19:
          pending_items.push_back(make_item(CMD_WRCTL, t, $urandom, 3'($urandom),
                                            random_env()));
        default:
          pending_items.push_back(make_item(CMD_TICK, 1'($urandom_range(0, 1)), $urandom,
                                            3'($urandom), random_env()));
      endcase
    end
    if ($urandom_range(0, 1))
      pending_items.push_back(make_item(CMD_STOP, 1'($urandom_range(0, 1)), $urandom,
                                        3'($urandom), random_env()));
  endtask

  // both sides keep going without gaps for a while
  function automatic bit calm_stretch();
    return items_accepted >= 800 && items_accepted < 1000;
  endfunction

  // item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!offer_pending) begin
      if (pending_items.size() != 0 &&
          !(items_offered == DRAIN_AT && expected_results.size() != 0) &&
          (calm_stretch() || $urandom_range(0, 99) >= 10)) begin
        offered_item = pending_items.pop_front();
        offer_pending = 1'b1;
        items_offered++;
        in_ch.command         <= offered_item.command;
        in_ch.chip            <= offered_item.chip;
        in_ch.value           <= offered_item.value;
        in_ch.new_run         <= offered_item.new_run;
        in_ch.new_intr_enable <= offered_item.new_intr_enable;
        in_ch.new_wake_enable <= offered_item.new_wake_enable;
        in_ch.cpu_sleeping    <= offered_item.cpu_sleeping;
        in_ch.int_enable      <= offered_item.int_enable;
        in_ch.master_enabled  <= offered_item.master_enabled;
        in_ch.valid           <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && !long_hold_done && items_accepted >= LONG_HOLD_AT) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm_stretch() || $urandom_range(0, 99) >= 10;
      end
    end
  end

  // monitor: predict on input accept, check on result accept
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(predict_timer_step(offered_item));
      items_accepted++;
      offer_pending = 1'b0;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      observed.timer_value      = out_ch.timer_value;
      observed.run_bit          = out_ch.run_bit;
      observed.intr_bit         = out_ch.intr_bit;
      observed.wake_bit         = out_ch.wake_bit;
      observed.service_request  = out_ch.service_request;
      observed.interrupt_raised = out_ch.interrupt_raised;
      observed.wake_raised      = out_ch.wake_raised;
      if (expected_results.size() == 0)
        report_mismatch("result with none pending", observed.timer_value, '0);
      else
        check_result(observed, expected_results.pop_front());
      results_checked++;
    end
  end

  // stimulus, reset and end of run
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.chip = 1'b0;
    in_ch.value = '0;
    in_ch.new_run = 1'b0;
    in_ch.new_intr_enable = 1'b0;
    in_ch.new_wake_enable = 1'b0;
    in_ch.cpu_sleeping = 1'b0;
    in_ch.int_enable = 1'b0;
    in_ch.master_enabled = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_count[i] = '0;
      tmr_ctl[i] = '0;
      tmr_started[i] = 1'b0;
    end

    // directed: refused starts, underflow, holds, wake, stop chain, spare codes
    pending_items.push_back(make_item(CMD_READ,   1'b0, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_TICK,   1'b1, 32'hFFFF_FFFF, 3'b000, 3'b111));
    pending_items.push_back(make_item(CMD_WRCTL,  1'b1, 32'h0,         3'b110, 3'b011));
    pending_items.push_back(make_item(CMD_START,  1'b1, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_WRCTL,  1'b0, 32'h0,         3'b111, 3'b011));
    pending_items.push_back(make_item(CMD_START,  1'b0, 32'h0,         3'b000, 3'b010));
    pending_items.push_back(make_item(CMD_WRITE,  1'b0, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_START,  1'b0, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_START,  1'b0, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_START,  1'b1, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_WRITE,  1'b1, 32'hFFFF_FFFF, 3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_TICK,   1'b0, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_READ,   1'b0, 32'h0,         3'b000, 3'b111));
    pending_items.push_back(make_item(CMD_WRITE,  1'b0, 32'h8000_0000, 3'b000, 3'b100));
    pending_items.push_back(make_item(CMD_TICK,   1'b0, 32'h0,         3'b000, 3'b001));
    pending_items.push_back(make_item(CMD_WRITE,  1'b0, 32'h7FFF_FFFF, 3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_READ,   1'b1, 32'h0,         3'b000, 3'b000));
    pending_items.push_back(make_item(CMD_STOP,   1'b0, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_TICK,   1'b0, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_SPARE6, 1'b1, 32'h5A5A_A5A5, 3'b111, 3'b111));
    pending_items.push_back(make_item(CMD_SPARE7, 1'b0, 32'hFFFF_FFFF, 3'b111, 3'b110));
    pending_items.push_back(make_item(CMD_WRCTL,  1'b0, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_STOP,   1'b1, 32'h0,         3'b000, 3'b011));
    pending_items.push_back(make_item(CMD_START,  1'b0, 32'h0,         3'b000, 3'b011));

    // random: mostly timer run-down sequences, some noise
    while (pending_items.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 7) queue_timer_sequence();
      else pending_items.push_back(noise_item());
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_items.size() != 0 || offer_pending) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
src/dcti_pkg.sv
src/dcti_if.sv
src/dcti_core.sv
src/dual_countdown_timer_irq_wake_unit.sv
src/dcti_checker.sv
tb/dual_countdown_timer_irq_wake_unit_tb.sv
